// ----- hw/rtl/cfa_pkg.sv -----
// Package with the transaction types and constants of the contiguous fit allocator.
package cfa_pkg;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_COMPACT = 2'd2;
   localparam logic [1:0] CMD_READ    = 2'd3;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_WORST = 2'd1;
   localparam logic [1:0] FIT_BEST  = 2'd2;

   localparam logic [7:0] FREE_MARK = 8'd46;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] owner;
      logic [7:0] request_size;
      logic [1:0] fit_policy;
      logic [6:0] cell_address;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [6:0] start_cell;
      logic [7:0] cell_owner;
   } rsp_type;

endpackage

// ----- hw/rtl/contiguous_fit_allocator.sv -----
// Top level of the contiguous fit allocator: sequencer around the pool memory.
//
// The pool of POOL_CELLS owner bytes lives in one synchronous memory with
// one write and one read port. After reset a clearing pass writes the free
// mark into every cell, during which no transaction is taken. Free streams
// the pool once. Compact streams the pool once and then writes the free
// mark above the moved cells. Allocate scans the pool once to pick a hole
// and then writes the run. One transaction is worked on at a time; a
// finished result is held until the response register is free, and the
// next transaction is taken as soon as the sequencer is idle again, even
// while the previous result still waits.
module contiguous_fit_allocator
   import cfa_pkg::*;
#(
   parameter int POOL_CELLS = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(POOL_CELLS);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] POOL_N = CW'(POOL_CELLS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_FILL  = 3'd3;
   localparam logic [2:0] ST_TAIL  = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]    state_ff, state_in;
   req_type       req_ff, req_in;
   logic [CW-1:0] rd_cnt_ff, rd_cnt_in;   // next read address issued
   logic          rd_vld_ff, rd_vld_in;   // read data valid this cycle
   logic [CW-1:0] pos_ff, pos_in;         // index of cell in rd_data
   logic [CW-1:0] wp_ff, wp_in;           // write pointer
   logic [CW-1:0] run_st_ff, run_st_in;
   logic [CW-1:0] run_len_ff, run_len_in;
   logic          have_ff, have_in;
   logic [CW-1:0] pk_st_ff, pk_st_in;
   logic [CW-1:0] pk_len_ff, pk_len_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   cfa_pool_mem #(.POOL_CELLS(POOL_CELLS), .AW(AW)) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic          size_ok;
   logic          alloc_ok;
   logic          rsp_free;
   logic [CW-1:0] size_cw;
   logic          cell_free, end_of_run, run_ok;
   logic [CW-1:0] run_len_now;

   assign size_cw  = CW'(req_ff.request_size);
   assign size_ok  = (req_ff.request_size != 8'd0) && (req_ff.fit_policy != 2'd3) &&
                     (int'(req_ff.request_size) <= POOL_CELLS);
   assign alloc_ok = size_ok && have_ff && (pk_len_ff >= size_cw);
   // The response register can take a new result this cycle.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_vld_in    = 1'b0;
      pos_in       = pos_ff;
      wp_in        = wp_ff;
      run_st_in    = run_st_ff;
      run_len_in   = run_len_ff;
      have_in      = have_ff;
      pk_st_in     = pk_st_ff;
      pk_len_in    = pk_len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = wp_ff[AW-1:0];
      wr_data      = FREE_MARK;
      rd_addr      = rd_cnt_ff[AW-1:0];
      cell_free    = 1'b0;
      end_of_run   = 1'b0;
      run_ok       = 1'b0;
      run_len_now  = run_len_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wp_in = wp_ff + 1'b1;
            if (wp_ff == POOL_N - 1'b1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               req_in    = req_data;
               rd_cnt_in = '0;
               pos_in    = '0;
               wp_in     = '0;
               run_len_in = '0;
               run_st_in = '0;
               have_in   = 1'b0;
               pk_st_in  = '0;
               pk_len_in = '0;
               unique case (req_data.cmd)
                  CMD_READ: state_in = ST_READ;
                  default:  state_in = ST_SCAN;
               endcase
               rd_addr = AW'(req_data.cell_address);
            end
         end
         ST_READ: begin
            // rd_data holds the addressed cell; keep reading it while the result waits.
            rd_addr = AW'(req_ff.cell_address);
            if (rsp_free) begin
               rsp_in.status     = 1'b0;
               rsp_in.start_cell = '0;
               rsp_in.cell_owner = (int'(req_ff.cell_address) < POOL_CELLS) ?
                                   rd_data : FREE_MARK;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // Issue reads across the pool.
            if (rd_cnt_ff < POOL_N) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               pos_in = pos_ff + 1'b1;
               unique case (req_ff.cmd)
                  CMD_FREE: begin
                     if (rd_data == req_ff.owner) begin
                        wr_en   = 1'b1;
                        wr_addr = pos_ff[AW-1:0];
                        wr_data = FREE_MARK;
                     end
                  end
                  CMD_COMPACT: begin
                     if (rd_data != FREE_MARK) begin
                        wr_en   = 1'b1;
                        wr_addr = wp_ff[AW-1:0];
                        wr_data = rd_data;
                        wp_in   = wp_ff + 1'b1;
                     end
                  end
                  default: begin
                     // Allocate: hole tracking.
                     cell_free = (rd_data == FREE_MARK);
                     if (cell_free) begin
                        if (run_len_ff == '0) run_st_in = pos_ff;
                        run_len_in = run_len_ff + 1'b1;
                     end else begin
                        end_of_run = 1'b1;
                        run_len_in = '0;
                     end
                  end
               endcase
            end
            // Close a run at the end of the pool as well.
            if (req_ff.cmd == CMD_ALLOC && !rd_vld_ff && rd_cnt_ff == POOL_N) begin
               end_of_run = 1'b1;
            end
            if (end_of_run && run_len_ff != '0) begin
               run_len_now = run_len_ff;
               if (req_ff.fit_policy == FIT_WORST) begin
                  if (run_len_now > pk_len_ff) run_ok = 1'b1;
               end else if (req_ff.fit_policy == FIT_BEST) begin
                  if (run_len_now >= size_cw && (!have_ff || run_len_now < pk_len_ff))
                     run_ok = 1'b1;
               end else if (req_ff.fit_policy == FIT_FIRST) begin
                  if (run_len_now >= size_cw && !have_ff) run_ok = 1'b1;
               end
               if (run_ok) begin
                  have_in   = 1'b1;
                  pk_len_in = run_len_now;
                  pk_st_in  = run_st_ff;
               end
            end
            if (!rd_vld_ff && rd_cnt_ff == POOL_N) begin
               unique case (req_ff.cmd)
                  CMD_COMPACT: state_in = ST_TAIL;
                  CMD_ALLOC: begin
                     if (size_ok && (have_in && pk_len_in >= size_cw)) begin
                        wp_in    = pk_st_in;
                        rd_cnt_in = '0;
                        state_in = ST_FILL;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_FILL: begin
            // Write the owner into the chosen run.
            wr_en     = 1'b1;
            wr_addr   = wp_ff[AW-1:0];
            wr_data   = req_ff.owner;
            wp_in     = wp_ff + 1'b1;
            rd_cnt_in = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff + 1'b1 == size_cw || wp_ff == POOL_N - 1'b1) begin
               state_in = ST_DONE;
            end
         end
         ST_TAIL: begin
            // Free mark above the compacted cells.
            if (wp_ff >= POOL_N) begin
               state_in = ST_DONE;
            end else begin
               wr_en = 1'b1;
               wp_in = wp_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // Hand the result over once the response register is free.
            if (rsp_free) begin
               rsp_in.status     = 1'b0;
               rsp_in.start_cell = '0;
               rsp_in.cell_owner = '0;
               if (req_ff.cmd == CMD_ALLOC) begin
                  if (alloc_ok) rsp_in.start_cell = 7'(pk_st_ff);
                  else rsp_in.status = 1'b1;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wp_ff        <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rd_cnt_ff  <= rd_cnt_in;
      pos_ff     <= pos_in;
      run_st_ff  <= run_st_in;
      run_len_ff <= run_len_in;
      have_ff    <= have_in;
      pk_st_ff   <= pk_st_in;
      pk_len_ff  <= pk_len_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// ----- hw/rtl/cfa_pool_mem.sv -----
// Pool memory: one synchronous write port and one registered read port.
module cfa_pool_mem
   import cfa_pkg::*;
#(
   parameter int POOL_CELLS = 128,
   parameter int AW = 7
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [POOL_CELLS];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- sim/contiguous_fit_allocator_test.sv -----
// Self-checking testbench for the contiguous fit allocator: directed and random commands.
module contiguous_fit_allocator_test;
   import cfa_pkg::*;

   localparam int CELLS = 128;
   localparam int STALL_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   contiguous_fit_allocator #(.POOL_CELLS(CELLS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Predicted pool contents and outstanding responses.
   logic [7:0] pool_model [CELLS];
   rsp_type    pending_rsps [$];
   int         mismatches;
   int         idle_cycles;
   int         send_gap_pct;
   int         recv_gap_pct;
   bit         hold_rsp;
   bit         timed_out;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Finds a hole in the predicted pool; returns 1 and the start on success.
   function automatic bit find_hole(input logic [1:0] policy, input int size,
                                    output int start);
      bit have;
      int pick_start, pick_len, run_start, run_len;
      bit is_free;
      have = 0; pick_start = 0; pick_len = 0; run_start = 0; run_len = 0;
      start = 0;
      for (int i = 0; i <= CELLS; i++) begin
         is_free = (i < CELLS) && (pool_model[i] == FREE_MARK);
         if (is_free) begin
            if (run_len == 0) run_start = i;
            run_len++;
            if (policy == FIT_FIRST && run_len >= size) begin
               start = run_start;
               return 1;
            end
         end else begin
            if (run_len > 0) begin
               if (policy == FIT_WORST && run_len > pick_len) begin
                  have = 1; pick_len = run_len; pick_start = run_start;
               end else if (policy == FIT_BEST && run_len >= size &&
                            (!have || run_len < pick_len)) begin
                  have = 1; pick_len = run_len; pick_start = run_start;
               end
            end
            run_len = 0;
         end
      end
      if (have && pick_len >= size) begin
         start = pick_start;
         return 1;
      end
      return 0;
   endfunction

   // Applies one command to the predicted pool and returns the expected response.
   function automatic rsp_type apply_command(input req_type r);
      rsp_type o;
      int start, dst, size;
      o = '0;
      size = r.request_size;
      case (r.cmd)
         CMD_ALLOC: begin
            if (size == 0 || r.fit_policy > FIT_BEST || size > CELLS ||
                !find_hole(r.fit_policy, size, start)) begin
               o.status = 1'b1;
            end else begin
               for (int i = 0; i < size && start + i < CELLS; i++)
                  pool_model[start + i] = r.owner;
               o.start_cell = start[6:0];
            end
         end
         CMD_FREE: begin
            for (int i = 0; i < CELLS; i++)
               if (pool_model[i] == r.owner) pool_model[i] = FREE_MARK;
         end
         CMD_COMPACT: begin
            dst = 0;
            for (int i = 0; i < CELLS; i++)
               if (pool_model[i] != FREE_MARK) begin
                  pool_model[dst] = pool_model[i];
                  dst++;
               end
            for (int i = dst; i < CELLS; i++) pool_model[i] = FREE_MARK;
         end
         default: begin
            o.cell_owner = (r.cell_address < CELLS) ? pool_model[r.cell_address]
                                                    : FREE_MARK;
         end
      endcase
      return o;
   endfunction

   // Offers one transaction, with an optional random gap, and predicts it.
   // Valid stays high after acceptance until the next transaction or a stop.
   task automatic send_command(input req_type r);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsps.push_back(apply_command(r));
   endtask

   // Drops valid after the last transaction of a sequence.
   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_cmd(input logic [1:0] c, input logic [7:0] own,
                                        input logic [7:0] size, input logic [1:0] pol,
                                        input logic [6:0] addr);
      req_type r;
      r.cmd = c; r.owner = own; r.request_size = size;
      r.fit_policy = pol; r.cell_address = addr;
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   // Random allocation owners avoid the free mark except now and then.
   function automatic logic [7:0] pick_owner();
      logic [7:0] o;
      if ($urandom_range(15) == 0) return 8'($urandom);
      o = 8'($urandom_range(1, 12)) + 8'd64;
      return o;
   endfunction

   // One random transaction, weighted toward allocate and free.
   function automatic req_type random_cmd();
      int k;
      logic [7:0] size;
      k = $urandom_range(99);
      if ($urandom_range(9) == 0) size = 8'($urandom);
      else size = 8'($urandom_range(1, 24));
      if (k < 45)
         return make_cmd(CMD_ALLOC, pick_owner(), size,
                         ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)),
                         7'($urandom));
      else if (k < 70)
         return make_cmd(CMD_FREE, pick_owner(), 8'($urandom), 2'($urandom),
                         7'($urandom));
      else if (k < 78)
         return make_cmd(CMD_COMPACT, 8'($urandom), 8'($urandom), 2'($urandom),
                         7'($urandom));
      return make_cmd(CMD_READ, 8'($urandom), 8'($urandom), 2'($urandom),
                      7'($urandom));
   endfunction

   // Directed: field extremes, every command and every special case.
   task automatic test_directed();
      send_command(make_cmd(CMD_READ, 8'hFF, 8'hFF, 2'd3, 7'd0));
      send_command(make_cmd(CMD_READ, 8'h00, 8'h00, 2'd0, 7'd127));
      send_command(make_cmd(CMD_ALLOC, 8'h41, 8'd0, FIT_FIRST, 7'd0));
      send_command(make_cmd(CMD_ALLOC, 8'h41, 8'd129, FIT_FIRST, 7'd0));
      send_command(make_cmd(CMD_ALLOC, 8'h41, 8'd255, FIT_BEST, 7'd0));
      send_command(make_cmd(CMD_ALLOC, 8'h41, 8'd4, 2'd3, 7'd0));
      send_command(make_cmd(CMD_ALLOC, 8'h41, 8'd128, FIT_WORST, 7'd0));
      send_command(make_cmd(CMD_ALLOC, 8'h42, 8'd1, FIT_FIRST, 7'd0));
      send_command(make_cmd(CMD_READ, 8'h00, 8'h00, 2'd0, 7'd127));
      send_command(make_cmd(CMD_FREE, 8'h41, 8'd0, 2'd0, 7'd0));
      send_command(make_cmd(CMD_ALLOC, 8'hFF, 8'd10, FIT_FIRST, 7'd0));
      send_command(make_cmd(CMD_ALLOC, 8'h00, 8'd5, FIT_FIRST, 7'd0));
      send_command(make_cmd(CMD_ALLOC, 8'h01, 8'd20, FIT_FIRST, 7'd0));
      send_command(make_cmd(CMD_FREE, 8'h00, 8'd0, 2'd0, 7'd0));
      send_command(make_cmd(CMD_ALLOC, 8'h02, 8'd3, FIT_BEST, 7'd0));
      send_command(make_cmd(CMD_ALLOC, 8'h03, 8'd3, FIT_WORST, 7'd0));
      send_command(make_cmd(CMD_ALLOC, FREE_MARK, 8'd4, FIT_FIRST, 7'd0));
      send_command(make_cmd(CMD_FREE, FREE_MARK, 8'd0, 2'd0, 7'd0));
      send_command(make_cmd(CMD_COMPACT, 8'h00, 8'd0, 2'd0, 7'd0));
      send_command(make_cmd(CMD_READ, 8'h00, 8'd0, 2'd0, 7'd0));
      send_command(make_cmd(CMD_READ, 8'h00, 8'd0, 2'd0, 7'd12));
      send_command(make_cmd(CMD_FREE, 8'hFF, 8'd0, 2'd0, 7'd0));
      send_command(make_cmd(CMD_ALLOC, 8'h07, 8'd200, FIT_WORST, 7'd0));
      stop_sending();
   endtask

   task automatic test_random(input int count, input int s_pct, input int r_pct);
      send_gap_pct = s_pct;
      recv_gap_pct = r_pct;
      repeat (count) send_command(random_cmd());
      stop_sending();
   endtask

   // Receiver holds off while the sender keeps offering, then the sender pauses.
   task automatic test_backpressure();
      send_gap_pct = 0;
      hold_rsp = 1'b1;
      fork
         begin
            repeat (2000) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            repeat (12) send_command(random_cmd());
            stop_sending();
         end
      join
      wait_drained();
   endtask

   // Checks every response against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            rsp_type want;
            want = pending_rsps.pop_front();
            if (rsp_data.status !== want.status || rsp_data.start_cell !== want.start_cell ||
                rsp_data.cell_owner !== want.cell_owner) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %b/%0d/%0d got %b/%0d/%0d",
                           want.status, want.start_cell, want.cell_owner,
                           rsp_data.status, rsp_data.start_cell, rsp_data.cell_owner);
            end
         end
      end
   end

   // Random response stalls.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_gap_pct);
   end

   // Watchdog on cycles with no accepted transaction and no taken response.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      hold_rsp = 1'b0;
      mismatches = 0;
      idle_cycles = 0;
      timed_out = 1'b0;
      send_gap_pct = 0;
      recv_gap_pct = 0;
      for (int i = 0; i < CELLS; i++) pool_model[i] = FREE_MARK;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(560, 8, 46);
      test_backpressure();
      test_random(560, 46, 8);
      wait_drained();
      test_random(560, 0, 0);
      wait_drained();
      repeat (300) @(posedge clock);
      if (mismatches == 0 && pending_rsps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
